// ===== hdl/octc_pkg.sv =====
`timescale 1ns / 1ps

package octc_pkg;

  localparam int unsigned MinW    = 7;
  localparam int unsigned SecW    = 6;
  localparam int unsigned DigitW  = 4;

  localparam logic [SecW-1:0]   SECS_PER_MIN = SecW'(60);
  localparam logic [MinW-1:0]   MAX_MINUTES  = MinW'(99);
  localparam logic [1:0]        MAX_DIGITS   = 2'd2;
  localparam logic [1:0]        CANCEL_COUNT = 2'd2;
  localparam logic [DigitW-1:0] MAX_DIGIT    = DigitW'(9);

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  // One control pass as it arrives on the input stream.
  typedef struct packed {
    logic              second_tick;
    logic [DigitW-1:0] key_digit;
    logic              key_valid;
    logic              stop_press;
    logic              start_press;
    logic              food_present;
    logic              door_open;
  } octc_in_t;

  // Controller state carried from pass to pass.
  typedef struct packed {
    logic            start_request;
    logic [1:0]      stop_presses;
    logic [MinW-1:0] minutes_left;
    logic [SecW-1:0] seconds_left;
    logic [1:0]      digits_entered;
    logic            running;
    logic            tick_pending;
    logic            lamp_state;
    logic [MinW-1:0] display_minutes;
    logic [SecW-1:0] display_seconds;
  } octc_state_t;

  // Result of one pass, lowest field in the lowest bits.
  typedef struct packed {
    logic [SecW-1:0] shown_seconds;
    logic [MinW-1:0] shown_minutes;
    logic            cooking;
    logic            magnetron_on;
    logic            lamp_on;
    logic            heater_on;
  } octc_out_t;

endpackage

// ===== hdl/octc_step.sv =====
`timescale 1ns / 1ps

// Next state of the controller for one pass.
module octc_step import octc_pkg::*; (
  input  octc_in_t    item,
  input  octc_state_t cur,
  output octc_state_t nxt
);

  logic [MinW+3:0] entered;   // minutes * 10 + digit, up to 999
  logic [SecW-1:0] sec_dec;

  always_comb begin
    nxt     = cur;
    entered = '0;
    sec_dec = '0;

    if (item.start_press) begin
      nxt.start_request = 1'b1;
    end
    if (item.stop_press) begin
      nxt.stop_presses = cur.stop_presses + 2'd1;
    end
    if (item.second_tick) begin
      nxt.tick_pending = 1'b1;
    end

    // countdown
    if (nxt.running && nxt.tick_pending) begin
      if (nxt.minutes_left != '0) begin
        sec_dec = (nxt.seconds_left != '0) ? nxt.seconds_left - SecW'(1) : '0;
        nxt.display_minutes = nxt.minutes_left - MinW'(1);
        nxt.display_seconds = sec_dec;
        if (sec_dec == '0) begin
          nxt.minutes_left = nxt.minutes_left - MinW'(1);
          nxt.seconds_left = SECS_PER_MIN;
        end else begin
          nxt.seconds_left = sec_dec;
        end
      end else begin
        nxt.display_minutes = '0;
        nxt.display_seconds = '0;
        nxt.start_request   = 1'b0;
        nxt.running         = 1'b0;
        nxt.lamp_state      = 1'b0;
      end
      nxt.tick_pending = 1'b0;
    end

    if (item.door_open) begin
      nxt.lamp_state = 1'b1;
    end else if (!nxt.start_request) begin
      nxt.lamp_state = 1'b0;
    end

    // keypad entry and start, only with food in and door shut
    if (item.food_present && !item.door_open) begin
      if (nxt.digits_entered < MAX_DIGITS && item.key_valid && item.key_digit <= MAX_DIGIT) begin
        entered = ({4'd0, nxt.minutes_left} << 3) + ({4'd0, nxt.minutes_left} << 1)
                + {(MinW)'(0), item.key_digit};
        if (entered > {4'd0, MAX_MINUTES}) begin
          entered = {4'd0, MAX_MINUTES};
        end
        nxt.minutes_left    = entered[MinW-1:0];
        nxt.display_minutes = entered[MinW-1:0];
        nxt.digits_entered  = nxt.digits_entered + 2'd1;
      end
      if (nxt.start_request && !item.stop_press) begin
        nxt.running      = 1'b1;
        nxt.lamp_state   = 1'b1;
        nxt.stop_presses = '0;
      end
    end

    if (item.stop_press) begin
      nxt.start_request = 1'b0;
      nxt.running       = 1'b0;
      nxt.lamp_state    = 1'b0;
    end

    // second stop press: cancel everything but a pending tick
    if (nxt.stop_presses == CANCEL_COUNT) begin
      nxt.running         = 1'b0;
      nxt.lamp_state      = 1'b0;
      nxt.display_minutes = '0;
      nxt.display_seconds = '0;
      nxt.start_request   = 1'b0;
      nxt.minutes_left    = '0;
      nxt.seconds_left    = SECS_PER_MIN;
      nxt.stop_presses    = '0;
      nxt.digits_entered  = '0;
    end
  end

endmodule

// ===== hdl/oven_cook_timer_controller_core.sv =====
`timescale 1ns / 1ps

// Channel  | dir | handshake              | payload
// ---------+-----+------------------------+-----------------------------------------
// s_axis   | in  | s_axis_tvalid/tready   | tdata[15:0]  one control pass
// m_axis   | out | m_axis_tvalid/tready   | tdata[23:0]  drives and display
//
// One item per cycle sustained while m_axis is ready; each item passes the input
// register, then the pass logic into the result register and the controller state.
// A pass advances only when the result register is empty or being taken,
// so a stall on m_axis backs up into s_axis after the input register fills.
// rst is synchronous, active high: clears both valid flags and the state
// (seconds_left comes up at 60, all else at zero).
module oven_cook_timer_controller_core import octc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] door_open, [1] food_present, [2] start_press, [3] stop_press,
  // [4] key_valid, [8:5] key_digit, [9] second_tick, [15:10] ignored
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] heater_on, [1] lamp_on, [2] magnetron_on, [3] cooking,
  // [10:4] shown_minutes, [16:11] shown_seconds, [23:17] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned InUsedW  = $bits(octc_in_t);
  localparam int unsigned OutUsedW = $bits(octc_out_t);

  // Controller state right after reset.
  localparam octc_state_t StateReset = '{
    start_request:   1'b0,
    stop_presses:    2'd0,
    minutes_left:    '0,
    seconds_left:    SECS_PER_MIN,
    digits_entered:  2'd0,
    running:         1'b0,
    tick_pending:    1'b0,
    lamp_state:      1'b0,
    display_minutes: '0,
    display_seconds: '0
  };

  logic        in_valid;
  octc_in_t    in_item;
  logic        out_valid;
  octc_out_t   out_item;
  octc_state_t state;
  octc_state_t state_next;
  logic        advance;

  // The pass runs when an item sits in the input register and the
  // result register can take its outcome this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item <= octc_in_t'(s_axis_tdata[InUsedW-1:0]);
    end
  end

  octc_step u_step (
    .item (in_item),
    .cur  (state),
    .nxt  (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.heater_on     <= state_next.running;
      out_item.lamp_on       <= state_next.lamp_state;
      out_item.magnetron_on  <= state_next.running;
      out_item.cooking       <= state_next.running;
      out_item.shown_minutes <= state_next.display_minutes;
      out_item.shown_seconds <= state_next.display_seconds;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_item};

  // A second stop press is resolved within its own pass.
  a_no_held_cancel: assert property (@(posedge clk) disable iff (rst)
    state.stop_presses != CANCEL_COUNT)
    else $error("stop counter left at cancel count");

  // A run always has its start request and the lamp lit.
  a_run_lamp: assert property (@(posedge clk) disable iff (rst)
    state.running |-> (state.start_request && state.lamp_state))
    else $error("running without start request or lamp");

  // Seconds remaining stay within 1..60.
  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    (state.seconds_left != '0) && (state.seconds_left <= SECS_PER_MIN))
    else $error("seconds_left out of range");

  // Entered minutes saturate and at most two digits count.
  a_entry_range: assert property (@(posedge clk) disable iff (rst)
    (state.minutes_left <= MAX_MINUTES) && (state.digits_entered <= MAX_DIGITS))
    else $error("minutes or digit count out of range");

  // State moves only when a pass is taken.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(advance) && !$past(rst) |-> $stable(state))
    else $error("state changed without a pass");

endmodule
